/* design/infix_to_postfix_converter_macros.svh */
// assertion macros shared by the converter
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define ITP_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ITP_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/itp_pkg.sv */
package itp_pkg;

   // operator stack geometry
   localparam int STACK_DEPTH = 32;
   localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   // input token kinds
   localparam logic [3:0] CMD_NUMBER = 4'd0;
   localparam logic [3:0] CMD_PLUS   = 4'd1;
   localparam logic [3:0] CMD_MINUS  = 4'd2;
   localparam logic [3:0] CMD_TIMES  = 4'd3;
   localparam logic [3:0] CMD_DIVIDE = 4'd4;
   localparam logic [3:0] CMD_POWER  = 4'd5;
   localparam logic [3:0] CMD_OPEN   = 4'd6;
   localparam logic [3:0] CMD_CLOSE  = 4'd7;
   localparam logic [3:0] CMD_SYMBOL = 4'd8;
   localparam logic [3:0] CMD_END    = 4'd9;

   // output kinds, also the stack entry codes
   localparam logic [2:0] KIND_NUMBER = 3'd0;
   localparam logic [2:0] KIND_PLUS   = 3'd1;
   localparam logic [2:0] KIND_MINUS  = 3'd2;
   localparam logic [2:0] KIND_TIMES  = 3'd3;
   localparam logic [2:0] KIND_DIVIDE = 3'd4;
   localparam logic [2:0] KIND_POWER  = 3'd5;
   localparam logic [2:0] KIND_NEGATE = 3'd6;
   localparam logic [2:0] KIND_SYMBOL = 3'd7;
   localparam logic [2:0] ENTRY_OPEN  = 3'd0;

   // status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_OVERFLOW = 2'd1;
   localparam logic [1:0] STAT_CLOSE    = 2'd2;
   localparam logic [1:0] STAT_OPEN     = 2'd3;

   localparam logic [1:0] PRIO_POWER = 2'd3;

   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_OPERAND,
      CLS_OPERATOR,
      CLS_OPEN
   } token_class_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DISPATCH,
      ST_BINOP,
      ST_NEGATE,
      ST_CLOSE,
      ST_END,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic [7:0]  symbol;
      logic [1:0]  status;
   } result_type;

   // binding strength of an operator code, zero for an open parenthesis
   function automatic logic [1:0] op_priority(input logic [2:0] code);
      logic [1:0] p;
      case (code)
         KIND_PLUS, KIND_MINUS:   p = 2'd1;
         KIND_TIMES, KIND_DIVIDE: p = 2'd2;
         KIND_POWER:              p = PRIO_POWER;
         default:                 p = 2'd0;
      endcase
      return p;
   endfunction

endpackage

/* design/infix_to_postfix_converter.sv */
// Infix to postfix converter, shunting-yard method.
// Input channel req_*: one infix token per word (command, number value, symbol
// code). Output channel rsp_*: postfix tokens and error reports, one per word;
// rsp_last marks the final word caused by an input token. A token that causes
// no word (a held minus, a matched open, an unused code) produces nothing.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// Throughput: one token at a time. A number, symbol, open or held minus goes
// through accept, dispatch and finish; an operator, close or end adds a pop
// loop of one stack entry per step, a negation a negate step, and a held minus
// resolved as binary a pop loop and a redispatch. The pop loop sets the pace.
// The stack lives in a synchronous memory with one write and one read port;
// the top entry is read ahead every cycle, with forwarding when a push lands
// on the read address.
// Every output word is registered in the held word and then in the output
// word register before it is valid.
// A stalled output holds its word; the converter waits, never drops a word.
// Reset (synchronous, active high) empties the stack, clears the held minus
// and the token history; no clearing pass is needed, stack contents above
// the count are never read.
`include "infix_to_postfix_converter_macros.svh"

module infix_to_postfix_converter
   import itp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_command,
   input  logic signed [31:0] req_number_value,
   input  logic [7:0]  req_symbol_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_out_kind,
   output logic signed [31:0] rsp_out_value,
   output logic [7:0]  rsp_out_symbol,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   // control registers
   state_type       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   token_class_type prev_ff, prev_in;
   logic            pend_ff, pend_in;
   logic            open_seen_ff, open_seen_in;
   logic [2:0]      op_ff, op_in;
   logic            after_ff, after_in;
   logic            hold_valid_ff, hold_valid_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [3:0]      cmd_ff;
   logic [31:0]     value_ff;
   logic [7:0]      sym_ff;
   result_type      hold_ff, hold_in;
   result_type      rsp_word_ff;
   logic            rsp_last_ff;

   // stack memory and read-ahead top
   logic [2:0]       stack_mem [STACK_DEPTH];
   logic [2:0]       top_ff;
   logic             stk_we;
   logic [PTR_W-1:0] stk_waddr;
   logic [2:0]       stk_wdata;
   logic [PTR_W-1:0] stk_raddr;
   logic [CNT_W-1:0] count_dec;

   logic       req_accept;
   logic       go;
   logic       do_dispatch;
   logic       do_push;
   logic [2:0] push_code;
   logic       emit_en;
   result_type emit_res;
   logic       finish;
   logic       out_load;
   logic       out_last;
   logic       binop_stop;
   logic       stack_full;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign go         = !rsp_valid_ff || !rsp_stall;
   assign stack_full = (count_ff == CNT_W'(STACK_DEPTH));
   assign binop_stop = (count_ff == '0) || (op_priority(op_ff) == PRIO_POWER)
                       || (op_priority(op_ff) > op_priority(top_ff));

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      prev_in      = prev_ff;
      pend_in      = pend_ff;
      open_seen_in = open_seen_ff;
      op_in        = op_ff;
      after_in     = after_ff;
      do_dispatch  = 1'b0;
      do_push      = 1'b0;
      push_code    = ENTRY_OPEN;
      emit_en      = 1'b0;
      emit_res     = '0;
      finish       = 1'b0;
      stk_we       = 1'b0;
      stk_waddr    = count_ff[PTR_W-1:0];
      stk_wdata    = push_code;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_command <= CMD_END) state_in = ST_START;
         end
         ST_START: begin
            if (go) begin
               if (pend_ff) begin
                  pend_in = 1'b0;
                  if (cmd_ff == CMD_NUMBER) begin
                     emit_en        = 1'b1;
                     emit_res.kind  = KIND_NUMBER;
                     emit_res.value = value_ff;
                     state_in       = ST_NEGATE;
                  end else begin
                     op_in    = KIND_MINUS;
                     after_in = 1'b1;
                     state_in = ST_BINOP;
                  end
               end else begin
                  do_dispatch = 1'b1;
               end
            end
         end
         ST_DISPATCH: begin
            if (go) do_dispatch = 1'b1;
         end
         ST_BINOP: begin
            if (go) begin
               if (!binop_stop) begin
                  count_in      = count_ff - CNT_W'(1);
                  emit_en       = 1'b1;
                  emit_res.kind = top_ff;
               end else begin
                  do_push   = 1'b1;
                  push_code = op_ff;
                  prev_in   = CLS_OPERATOR;
                  state_in  = after_ff ? ST_DISPATCH : ST_FINISH;
               end
            end
         end
         ST_NEGATE: begin
            if (go) begin
               emit_en       = 1'b1;
               emit_res.kind = KIND_NEGATE;
               prev_in       = CLS_OPERAND;
               state_in      = ST_FINISH;
            end
         end
         ST_CLOSE: begin
            if (go) begin
               if (count_ff != '0 && top_ff != ENTRY_OPEN) begin
                  count_in      = count_ff - CNT_W'(1);
                  emit_en       = 1'b1;
                  emit_res.kind = top_ff;
               end else begin
                  if (count_ff == '0) begin
                     emit_en         = 1'b1;
                     emit_res.status = STAT_CLOSE;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                  end
                  prev_in  = CLS_OPERAND;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_END: begin
            if (go) begin
               if (count_ff != '0) begin
                  count_in = count_ff - CNT_W'(1);
                  if (top_ff == ENTRY_OPEN) begin
                     open_seen_in = 1'b1;
                  end else begin
                     emit_en       = 1'b1;
                     emit_res.kind = top_ff;
                  end
               end else begin
                  if (open_seen_ff) begin
                     emit_en         = 1'b1;
                     emit_res.status = STAT_OPEN;
                  end
                  open_seen_in = 1'b0;
                  prev_in      = CLS_NONE;
                  state_in     = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (go) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // token handling once any held minus is resolved
      if (do_dispatch) begin
         case (cmd_ff)
            CMD_NUMBER: begin
               emit_en        = 1'b1;
               emit_res.kind  = KIND_NUMBER;
               emit_res.value = value_ff;
               prev_in        = CLS_OPERAND;
               state_in       = ST_FINISH;
            end
            CMD_MINUS: begin
               if (prev_ff != CLS_OPERAND) begin
                  pend_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  op_in    = KIND_MINUS;
                  after_in = 1'b0;
                  state_in = ST_BINOP;
               end
            end
            CMD_PLUS, CMD_TIMES, CMD_DIVIDE, CMD_POWER: begin
               op_in    = cmd_ff[2:0];
               after_in = 1'b0;
               state_in = ST_BINOP;
            end
            CMD_OPEN: begin
               do_push   = 1'b1;
               push_code = ENTRY_OPEN;
               prev_in   = CLS_OPEN;
               state_in  = ST_FINISH;
            end
            CMD_CLOSE: state_in = ST_CLOSE;
            CMD_SYMBOL: begin
               emit_en         = 1'b1;
               emit_res.kind   = KIND_SYMBOL;
               emit_res.symbol = sym_ff;
               prev_in         = CLS_OPERAND;
               state_in        = ST_FINISH;
            end
            CMD_END: state_in = ST_END;
            default: state_in = ST_FINISH;
         endcase
      end

      // push onto the stack, or report overflow when full
      if (do_push) begin
         if (stack_full) begin
            emit_en         = 1'b1;
            emit_res        = '0;
            emit_res.status = STAT_OVERFLOW;
         end else begin
            stk_we    = 1'b1;
            stk_wdata = push_code;
            count_in  = count_ff + CNT_W'(1);
         end
      end
   end

   // read address follows the next top of stack
   assign count_dec = count_in - CNT_W'(1);
   assign stk_raddr = count_dec[PTR_W-1:0];

   // one-word hold so the final word of a token can carry last
   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      out_load      = 1'b0;
      out_last      = 1'b0;
      if (emit_en) begin
         out_load      = hold_valid_ff;
         hold_in       = emit_res;
         hold_valid_in = 1'b1;
      end else if (finish) begin
         out_load      = hold_valid_ff;
         out_last      = 1'b1;
         hold_valid_in = 1'b0;
      end
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         prev_ff       <= CLS_NONE;
         pend_ff       <= 1'b0;
         open_seen_ff  <= 1'b0;
         op_ff         <= KIND_PLUS;
         after_ff      <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         prev_ff       <= prev_in;
         pend_ff       <= pend_in;
         open_seen_ff  <= open_seen_in;
         op_ff         <= op_in;
         after_ff      <= after_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // token capture, held word and output word
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req_command;
         value_ff <= req_number_value;
         sym_ff   <= req_symbol_code;
      end
      hold_ff <= hold_in;
      if (out_load) begin
         rsp_word_ff <= hold_ff;
         rsp_last_ff <= out_last;
      end
   end

   // operator stack memory with write-to-read forwarding
   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
      if (stk_we && stk_waddr == stk_raddr) begin
         top_ff <= stk_wdata;
      end else begin
         top_ff <= stack_mem[stk_raddr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_kind   = rsp_word_ff.kind;
   assign rsp_out_value  = rsp_word_ff.value;
   assign rsp_out_symbol = rsp_word_ff.symbol;
   assign rsp_status     = rsp_word_ff.status;
   assign rsp_last       = rsp_last_ff;

   // checks
   `ITP_ASSERT_NOW(a_push_in_range, stk_we, count_ff < CNT_W'(STACK_DEPTH), "push past stack depth")
   `ITP_ASSERT_NOW(a_out_free, out_load, !rsp_valid_ff || !rsp_stall, "output word overwritten")
   `ITP_ASSERT_NEXT(a_finish_drains, finish, !hold_valid_ff, "held word left after finish")
   `ITP_ASSERT_NOW(a_pop_nonempty, count_in < count_ff, count_ff != '0, "pop from empty stack")
   `ITP_ASSERT_NEXT(a_idle_after_finish, finish, state_ff == ST_IDLE && !req_stall, "no return to idle")

endmodule
